[design/kwm_pkg.sv]
// Shared constants, codes and types for the k-way sorted merge engine.
package kwm_pkg;

  localparam int unsigned LISTS      = 8;
  localparam int unsigned LIST_DEPTH = 64;

  localparam int unsigned LIST_W  = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int unsigned PTR_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned STORE_D = LISTS * LIST_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(STORE_D);

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TDATA_W  = 40;

  // item kinds
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_POPPED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  // one list head as seen by the minimum tree
  typedef struct packed {
    logic        valid;
    value_t      value;
  } head_t;

  // winner of the minimum tree
  typedef struct packed {
    logic              found;
    value_t            value;
    logic [LIST_W-1:0] list;
  } winner_t;

endpackage

[design/kwm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module kwm_ram #(
  parameter int unsigned  W  = 32,
  parameter int unsigned  D  = 512,
  localparam int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/kwm_min_tree.sv]
// Binary compare tree picking the smallest valid head; ties go to the lower list.
module kwm_min_tree (
  input  kwm_pkg::head_t   heads [kwm_pkg::LISTS],
  output kwm_pkg::winner_t win
);

  localparam int unsigned NP = 1 << kwm_pkg::LIST_W;

  kwm_pkg::winner_t node [2*NP];

  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_leaf
      if (g < kwm_pkg::LISTS) begin : g_used
        assign node[NP+g].found = heads[g].valid;
        assign node[NP+g].value = heads[g].value;
        assign node[NP+g].list  = kwm_pkg::LIST_W'(g);
      end else begin : g_pad
        assign node[NP+g] = '0;
      end
    end

    for (g = NP - 1; g >= 1; g--) begin : g_node
      logic take_left;
      // left wins on equality, keeping the lower list first
      assign take_left = node[2*g].found &&
                         (!node[2*g+1].found || (node[2*g].value <= node[2*g+1].value));
      assign node[g] = take_left ? node[2*g] : node[2*g+1];
    end
  endgenerate

  assign node[0] = '0;
  assign win     = node[1];

endmodule

[design/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge engine: list state, head registers, result register.
//
//  channel | dir | handshake        | payload
//  in_     | in  | tvalid / tready  | tuser: action; tdata: list_index, value
//  out_    | out | tvalid / tready  | tuser: status; tdata: out_value, out_list
//
// A push needs no refill, nor does a pop that empties its list or finds all lists empty.
// Any other pop refills: the list's next element is read from the element RAM into
// its head register in the cycle after the pop, and intake is held off for that cycle.
// The head registers of all lists are compared in one tree in the accept cycle.
// No clearing pass after reset: only counts, pointers, refill state and out valid clear.
// Outside refill, input is taken when the result slot is free or emptied in the same cycle.
module k_way_sorted_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_tuser,   // [0] action
  input  logic [kwm_pkg::TDATA_W-1:0]  in_tdata,   // [2:0] list_index, [34:3] value
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [kwm_pkg::STATUS_W-1:0] out_tuser,  // [1:0] status
  output logic [kwm_pkg::TDATA_W-1:0]  out_tdata   // [31:0] out_value, [34:32] out_list
);

  localparam int unsigned LW = kwm_pkg::LIST_W;
  localparam int unsigned PW = kwm_pkg::PTR_W;
  localparam int unsigned CW = kwm_pkg::CNT_W;
  localparam int unsigned AW = kwm_pkg::ADDR_W;

  logic [PW-1:0]         head_ptr_r [kwm_pkg::LISTS];
  logic [PW-1:0]         tail_ptr_r [kwm_pkg::LISTS];
  logic [CW-1:0]         fill_r     [kwm_pkg::LISTS];
  kwm_pkg::value_t       head_val_r [kwm_pkg::LISTS];
  logic                  refill_r;
  logic [LW-1:0]         refill_list_r;
  logic                  out_valid_r;
  logic [kwm_pkg::STATUS_W-1:0] out_status_r;
  kwm_pkg::value_t       out_value_r;
  logic [kwm_pkg::IDX_W-1:0]    out_list_r;

  kwm_pkg::head_t        heads [kwm_pkg::LISTS];
  kwm_pkg::winner_t      win;

  logic                  accept;
  logic                  action;
  logic [kwm_pkg::IDX_W-1:0] in_idx;
  logic [LW-1:0]         lst;
  kwm_pkg::value_t       in_val;
  logic                  in_range;
  logic                  push_ok;
  logic                  pop_ok;
  logic [PW-1:0]         next_head;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  kwm_pkg::value_t       ram_rdata;

  assign action = in_tuser;
  assign in_idx = in_tdata[kwm_pkg::IDX_W-1:0];
  assign in_val = in_tdata[kwm_pkg::IDX_W +: kwm_pkg::VALUE_W];
  assign lst    = LW'(in_idx);

  assign in_range = (32'(in_idx) < kwm_pkg::LISTS);

  // refill cycle blocks intake; otherwise take an item whenever the result slot frees
  assign in_tready = !refill_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      heads[i].valid = (fill_r[i] != '0);
      heads[i].value = head_val_r[i];
    end
  end

  kwm_min_tree u_tree (
    .heads (heads),
    .win   (win)
  );

  assign push_ok = accept && (action == kwm_pkg::ACT_PUSH) && in_range &&
                   (fill_r[lst] != CW'(kwm_pkg::LIST_DEPTH));
  assign pop_ok  = accept && (action == kwm_pkg::ACT_POP) && win.found;

  assign next_head = (head_ptr_r[win.list] == PW'(kwm_pkg::LIST_DEPTH - 1)) ?
                     '0 : head_ptr_r[win.list] + PW'(1);

  assign waddr = AW'(lst) * AW'(kwm_pkg::LIST_DEPTH) + AW'(tail_ptr_r[lst]);
  assign raddr = AW'(win.list) * AW'(kwm_pkg::LIST_DEPTH) + AW'(next_head);

  kwm_ram #(
    .W (kwm_pkg::VALUE_W),
    .D (kwm_pkg::STORE_D)
  ) u_store (
    .clk   (clk),
    .we    (push_ok),
    .waddr (waddr),
    .wdata (in_val),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // list pointers and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kwm_pkg::LISTS; i++) begin
        head_ptr_r[i] <= '0;
        tail_ptr_r[i] <= '0;
        fill_r[i]     <= '0;
      end
      refill_r      <= 1'b0;
      refill_list_r <= '0;
    end else begin
      refill_r <= 1'b0;
      if (push_ok) begin
        tail_ptr_r[lst] <= (tail_ptr_r[lst] == PW'(kwm_pkg::LIST_DEPTH - 1)) ?
                           '0 : tail_ptr_r[lst] + PW'(1);
        fill_r[lst]     <= fill_r[lst] + CW'(1);
      end
      if (pop_ok) begin
        head_ptr_r[win.list] <= next_head;
        fill_r[win.list]     <= fill_r[win.list] - CW'(1);
        refill_r             <= (fill_r[win.list] > CW'(1));
        refill_list_r        <= win.list;
      end
    end
  end

  // head registers: loaded on a push into an empty list, or from RAM after a pop
  always_ff @(posedge clk) begin
    if (push_ok && (fill_r[lst] == '0)) begin
      head_val_r[lst] <= in_val;
    end
    if (refill_r) begin
      head_val_r[refill_list_r] <= ram_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r <= '0;
      out_list_r  <= '0;
      if (action == kwm_pkg::ACT_PUSH) begin
        out_status_r <= push_ok ? kwm_pkg::ST_PUSHED : kwm_pkg::ST_FULL;
      end else if (win.found) begin
        out_status_r <= kwm_pkg::ST_POPPED;
        out_value_r  <= win.value;
        out_list_r   <= kwm_pkg::IDX_W'(win.list);
      end else begin
        out_status_r <= kwm_pkg::ST_EMPTY;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(kwm_pkg::TDATA_W - kwm_pkg::VALUE_W - kwm_pkg::IDX_W){1'b0}},
                       out_list_r, out_value_r};

endmodule

[test/tb_k_way_sorted_merge.sv]
// Self-checking testbench for the k-way sorted merge engine: push/pop traffic with stalls.
module tb_k_way_sorted_merge;
  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PAD_W       = TDATA_W - IDX_W - VALUE_W;

  typedef struct {
    logic [STATUS_W-1:0] status;
    value_t              value;
    logic [IDX_W-1:0]    list;
  } merge_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic                in_tuser;
  logic [TDATA_W-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [STATUS_W-1:0] out_tuser;
  logic [TDATA_W-1:0]  out_tdata;

  // predicted list state
  value_t lane_mem [LISTS][LIST_DEPTH];
  int     lane_head [LISTS];
  int     lane_tail [LISTS];
  int     lane_fill [LISTS];

  merge_result_t pending_results [$];
  merge_result_t want;
  int            mismatch_count = 0;
  int            items_sent     = 0;
  int            quiet_cycles   = 0;
  bit            send_idle_on   = 1'b1;
  bit            recv_idle_on   = 1'b1;
  bit            hold_req       = 1'b0;

  k_way_sorted_merge u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected result of one item, updating the predicted lists.
  function automatic merge_result_t predict_merge(logic act, logic [IDX_W-1:0] idx,
                                                  value_t val);
    merge_result_t r;
    bit            found;
    int            best;
    value_t        best_val;
    value_t        h;
    r.status = ST_FULL;
    r.value  = '0;
    r.list   = '0;
    found    = 1'b0;
    best     = 0;
    best_val = '0;
    if (act == ACT_PUSH) begin
      if (idx < LISTS && lane_fill[idx] < LIST_DEPTH) begin
        lane_mem[idx][lane_tail[idx]] = val;
        lane_tail[idx] = (lane_tail[idx] + 1) % LIST_DEPTH;
        lane_fill[idx]++;
        r.status = ST_PUSHED;
      end
    end else begin
      // strict less-than keeps the lower list on equal heads
      for (int i = 0; i < LISTS; i++) begin
        if (lane_fill[i] != 0) begin
          h = lane_mem[i][lane_head[i]];
          if (!found || h < best_val) begin
            found    = 1'b1;
            best     = i;
            best_val = h;
          end
        end
      end
      if (!found) begin
        r.status = ST_EMPTY;
      end else begin
        lane_head[best] = (lane_head[best] + 1) % LIST_DEPTH;
        lane_fill[best]--;
        r.status = ST_POPPED;
        r.value  = best_val;
        r.list   = best[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int lanes_held();
    int n;
    n = 0;
    for (int i = 0; i < LISTS; i++) n += lane_fill[i];
    return n;
  endfunction

  // Next value of an ascending list: repeats, small and large steps, clamped at the top.
  function automatic value_t next_ascending(value_t v);
    longint s;
    case ($urandom_range(0, 3))
      0: s = longint'(v);
      1: s = longint'(v) + $urandom_range(1, 16);
      default: s = longint'(v) + longint'($urandom_range(0, 32'h0FFF_FFFF));
    endcase
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    return value_t'(s[31:0]);
  endfunction

  task automatic send_item(input logic act, input logic [IDX_W-1:0] idx, input value_t val);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{PAD_W{1'b0}}, val, idx};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_merge(act, idx, val));
    items_sent++;
  endtask

  task automatic push_to(input int idx, input value_t val);
    send_item(ACT_PUSH, idx[IDX_W-1:0], val);
  endtask

  // list index and value are don't-care on a pop, so drive noise there
  task automatic pop_min();
    send_item(ACT_POP, IDX_W'($urandom_range(0, 7)), value_t'($urandom));
  endtask

  task automatic drain_lists();
    while (lanes_held() > 0) pop_min();
    pop_min();
  endtask

  task automatic test_empty_pop();
    pop_min();
    pop_min();
  endtask

  task automatic test_extremes_and_ties();
    push_to(0, value_t'(32'h8000_0000));
    push_to(0, -1);
    push_to(0, 0);
    push_to(0, value_t'(32'h7FFF_FFFF));
    push_to(1, value_t'(32'h8000_0000));
    push_to(7, 0);
    push_to(7, value_t'(32'h7FFF_FFFF));
    push_to(5, 5);
    push_to(3, 5);
    // out of order list: stored as given
    push_to(2, 10);
    push_to(2, -10);
    repeat (11) pop_min();
    pop_min();
  endtask

  task automatic test_full_and_wrap();
    value_t v;
    v = -1000;
    repeat (LIST_DEPTH) begin
      push_to(4, v);
      v = next_ascending(v);
    end
    push_to(4, v);
    push_to(6, value_t'(32'h7FFF_FFFF));
    repeat (30) pop_min();
    // refill across the pointer wrap
    repeat (30) begin
      push_to(4, v);
      v = next_ascending(v);
    end
    push_to(4, v);
    drain_lists();
  endtask

  task automatic test_backpressure();
    send_idle_on = 1'b0;
    hold_req     = 1'b1;
    for (int i = 0; i < 24; i++) push_to(i % LISTS, value_t'($urandom));
    repeat (16) pop_min();
    drain_lists();
    send_idle_on = 1'b1;
  endtask

  task automatic test_random_merge(input int item_goal);
    value_t lane_next [LISTS];
    int     lane_left [LISTS];
    int     left_total;
    int     pick;
    int     goal;
    value_t v;
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      left_total   = 0;
      for (int i = 0; i < LISTS; i++) begin
        lane_left[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        lane_next[i] = ($urandom_range(0, 5) == 0) ?
                       value_t'(32'h8000_0000 + $urandom_range(0, 3)) : value_t'($urandom);
        left_total  += lane_left[i];
      end
      while (left_total > 0) begin
        if ($urandom_range(0, 4) == 0) begin
          pop_min();
        end else begin
          pick = $urandom_range(0, LISTS - 1);
          while (lane_left[pick] == 0) pick = (pick + 1) % LISTS;
          // now and then a value that breaks the ascending order
          v = ($urandom_range(0, 15) == 0) ? value_t'($urandom) : lane_next[pick];
          push_to(pick, v);
          lane_next[pick] = next_ascending(lane_next[pick]);
          lane_left[pick]--;
          left_total--;
        end
      end
      drain_lists();
    end
  endtask

  task automatic test_random_noise(input int item_goal);
    for (int i = 0; i < item_goal; i++) begin
      if (i % 25 == 0) begin
        send_idle_on = ($urandom_range(0, 2) != 0);
        recv_idle_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 45) pop_min();
      else push_to($urandom_range(0, 7), value_t'($urandom));
    end
    drain_lists();
  endtask

  // result side: random stalls, one long hold when asked
  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = recv_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (n > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", out_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatch_count++;
        end
        if (value_t'(out_tdata[31:0]) !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, value_t'(out_tdata[31:0]));
          mismatch_count++;
        end
        if (out_tdata[34:32] !== want.list) begin
          $error("out_list: expected %0d, got %0d", want.list, out_tdata[34:32]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    for (int i = 0; i < LISTS; i++) begin
      lane_head[i] = 0;
      lane_tail[i] = 0;
      lane_fill[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pop();
    test_extremes_and_ties();
    test_full_and_wrap();
    test_backpressure();
    test_random_merge(900);
    test_random_noise(250);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
